[sv/mti_pkg.sv]
// ----------------------------------------------------------------------------
// mti_pkg
// Shared constants and types for the masked trilinear interpolation pipeline.
// ----------------------------------------------------------------------------
package mti_pkg;

    localparam int VALUE_BITS_DEFAULT       = 32;
    localparam int WEIGHT_FRAC_BITS_DEFAULT = 16;

    localparam int LERP_STAGES = 3;
    localparam int NUM_AXES    = 3;
    localparam int NUM_STAGES  = LERP_STAGES * NUM_AXES;

    localparam int Z_FIRST = 0;
    localparam int Y_FIRST = LERP_STAGES;
    localparam int X_FIRST = 2 * LERP_STAGES;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } pipe_ctrl_t;

endpackage

[sv/mti_flow.sv]
// ----------------------------------------------------------------------------
// mti_flow
// Valid chain and per-stage load enables; each stage moves on when it is
// empty or the stage after it moves on.
// ----------------------------------------------------------------------------
module mti_flow (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    output mti_pkg::pipe_ctrl_t ctrl
);

    localparam int N = mti_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N:0]   stage_ready;
    logic [N-1:0] load;

    always_comb
    begin
        stage_ready[N] = out_ready;
        for (int k = N - 1; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        load = stage_ready[N-1:0];
        for (int k = 0; k < N; k++)
        begin
            if (load[k])
            begin
                valid_next[k] = (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready   = stage_ready[0];
    assign out_valid  = valid_reg[N-1];
    assign ctrl.load  = load;
    assign ctrl.valid = valid_reg;

endmodule

[sv/mti_lerp.sv]
// ----------------------------------------------------------------------------
// mti_lerp
// Three-stage masked blend: lo + floor(w * (hi - lo) / ONE), with the weight
// forced to one or zero by the solid flags; carries the ORed fluid flag.
// ----------------------------------------------------------------------------
module mti_lerp #(
    parameter int VALUE_BITS       = mti_pkg::VALUE_BITS_DEFAULT,
    parameter int WEIGHT_FRAC_BITS = mti_pkg::WEIGHT_FRAC_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic [mti_pkg::LERP_STAGES-1:0]      load,
    input  logic signed [VALUE_BITS-1:0]         lo,
    input  logic signed [VALUE_BITS-1:0]         hi,
    input  logic [WEIGHT_FRAC_BITS:0]            weight,
    input  logic                                 lo_fluid,
    input  logic                                 hi_fluid,
    output logic signed [VALUE_BITS-1:0]         result,
    output logic                                 fluid
);

    localparam int VB = VALUE_BITS;
    localparam int WF = WEIGHT_FRAC_BITS;
    localparam logic [WF:0] WONE = {1'b1, {WF{1'b0}}};

    logic [WF:0]               w_sel;
    logic signed [VB:0]        diff_next;

    logic [WF:0]               w_s0_reg;
    logic signed [VB:0]        diff_s0_reg;
    logic signed [VB-1:0]      lo_s0_reg;
    logic                      fluid_s0_reg;

    logic signed [VB+WF+2:0]   prod_next;
    logic signed [VB+WF+2:0]   prod_s1_reg;
    logic signed [VB-1:0]      lo_s1_reg;
    logic                      fluid_s1_reg;

    logic signed [VB-1:0]      result_next;
    logic signed [VB-1:0]      result_reg;
    logic                      fluid_s2_reg;

    always_comb
    begin
        if (!lo_fluid)
        begin
            w_sel = WONE;
        end
        else if (!hi_fluid)
        begin
            w_sel = '0;
        end
        else if (weight > WONE)
        begin
            w_sel = WONE;
        end
        else
        begin
            w_sel = weight;
        end
        diff_next   = $signed({hi[VB-1], hi}) - $signed({lo[VB-1], lo});
        prod_next   = $signed({{(VB+1){1'b0}}, w_s0_reg})
                    * $signed({{(WF+2){diff_s0_reg[VB]}}, diff_s0_reg});
        result_next = lo_s1_reg + $signed(prod_s1_reg[WF+VB-1:WF]);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            w_s0_reg     <= w_sel;
            diff_s0_reg  <= diff_next;
            lo_s0_reg    <= lo;
            fluid_s0_reg <= lo_fluid || hi_fluid;
        end
        if (load[1])
        begin
            prod_s1_reg  <= prod_next;
            lo_s1_reg    <= lo_s0_reg;
            fluid_s1_reg <= fluid_s0_reg;
        end
        if (load[2])
        begin
            result_reg   <= result_next;
            fluid_s2_reg <= fluid_s1_reg;
        end
    end

    assign result = result_reg;
    assign fluid  = fluid_s2_reg;

endmodule

[sv/masked_trilinear_interpolation.sv]
// Pipeline: each accepted request goes through difference, multiply and add
// stages for z, then y, then x, before its result is valid.
// Throughput: one request per cycle; stalls hold each stage in place and
// bubbles are squeezed out stage by stage.
// Reset: rst_n clears all valid bits and sets masking_enable to 1.
// ----------------------------------------------------------------------------
// masked_trilinear_interpolation
// Blends eight cell values around a vertex in z, y and x with fluid masking.
// ----------------------------------------------------------------------------
module masked_trilinear_interpolation #(
    parameter int VALUE_BITS       = mti_pkg::VALUE_BITS_DEFAULT,
    parameter int WEIGHT_FRAC_BITS = mti_pkg::WEIGHT_FRAC_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [VALUE_BITS-1:0]  corner_000,
    input  logic signed [VALUE_BITS-1:0]  corner_100,
    input  logic signed [VALUE_BITS-1:0]  corner_010,
    input  logic signed [VALUE_BITS-1:0]  corner_001,
    input  logic signed [VALUE_BITS-1:0]  corner_101,
    input  logic signed [VALUE_BITS-1:0]  corner_011,
    input  logic signed [VALUE_BITS-1:0]  corner_110,
    input  logic signed [VALUE_BITS-1:0]  corner_111,
    input  logic [7:0]                    mask_bits,
    input  logic [WEIGHT_FRAC_BITS:0]     weight_x,
    input  logic [WEIGHT_FRAC_BITS:0]     weight_y,
    input  logic [WEIGHT_FRAC_BITS:0]     weight_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VALUE_BITS-1:0]  interpolated_value
);

    localparam int VB = VALUE_BITS;
    localparam int WF = WEIGHT_FRAC_BITS;
    localparam int LS = mti_pkg::LERP_STAGES;
    localparam int YF = mti_pkg::Y_FIRST;
    localparam int XF = mti_pkg::X_FIRST;
    localparam int ZF = mti_pkg::Z_FIRST;

    mti_pkg::pipe_ctrl_t ctrl;

    logic       masking_enable_reg;
    logic [7:0] fluid_in;

    logic [WF:0] wy_pipe_reg [YF];
    logic [WF:0] wx_pipe_reg [XF];

    logic signed [VB-1:0] c00, c10, c01, c11, c0, c1;
    logic                 m00, m10, m01, m11, m0, m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            masking_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            masking_enable_reg <= cfg_wdata;
        end
    end

    assign fluid_in = masking_enable_reg ? mask_bits : 8'hFF;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            wy_pipe_reg[0] <= weight_y;
            wx_pipe_reg[0] <= weight_x;
        end
        for (int k = 1; k < YF; k++)
        begin
            if (ctrl.load[k])
            begin
                wy_pipe_reg[k] <= wy_pipe_reg[k-1];
            end
        end
        for (int k = 1; k < XF; k++)
        begin
            if (ctrl.load[k])
            begin
                wx_pipe_reg[k] <= wx_pipe_reg[k-1];
            end
        end
    end

    mti_flow u_flow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .ctrl      (ctrl)
    );

    mti_lerp #(.VALUE_BITS(VB), .WEIGHT_FRAC_BITS(WF)) u_lerp_z00 (
        .clk(clk), .load(ctrl.load[ZF+LS-1:ZF]), .lo(corner_000), .hi(corner_001),
        .weight(weight_z), .lo_fluid(fluid_in[0]), .hi_fluid(fluid_in[4]),
        .result(c00), .fluid(m00)
    );

    mti_lerp #(.VALUE_BITS(VB), .WEIGHT_FRAC_BITS(WF)) u_lerp_z10 (
        .clk(clk), .load(ctrl.load[ZF+LS-1:ZF]), .lo(corner_100), .hi(corner_101),
        .weight(weight_z), .lo_fluid(fluid_in[1]), .hi_fluid(fluid_in[5]),
        .result(c10), .fluid(m10)
    );

    mti_lerp #(.VALUE_BITS(VB), .WEIGHT_FRAC_BITS(WF)) u_lerp_z01 (
        .clk(clk), .load(ctrl.load[ZF+LS-1:ZF]), .lo(corner_010), .hi(corner_011),
        .weight(weight_z), .lo_fluid(fluid_in[2]), .hi_fluid(fluid_in[6]),
        .result(c01), .fluid(m01)
    );

    mti_lerp #(.VALUE_BITS(VB), .WEIGHT_FRAC_BITS(WF)) u_lerp_z11 (
        .clk(clk), .load(ctrl.load[ZF+LS-1:ZF]), .lo(corner_110), .hi(corner_111),
        .weight(weight_z), .lo_fluid(fluid_in[3]), .hi_fluid(fluid_in[7]),
        .result(c11), .fluid(m11)
    );

    mti_lerp #(.VALUE_BITS(VB), .WEIGHT_FRAC_BITS(WF)) u_lerp_y0 (
        .clk(clk), .load(ctrl.load[YF+LS-1:YF]), .lo(c00), .hi(c01),
        .weight(wy_pipe_reg[YF-1]), .lo_fluid(m00), .hi_fluid(m01),
        .result(c0), .fluid(m0)
    );

    mti_lerp #(.VALUE_BITS(VB), .WEIGHT_FRAC_BITS(WF)) u_lerp_y1 (
        .clk(clk), .load(ctrl.load[YF+LS-1:YF]), .lo(c10), .hi(c11),
        .weight(wy_pipe_reg[YF-1]), .lo_fluid(m10), .hi_fluid(m11),
        .result(c1), .fluid(m1)
    );

    mti_lerp #(.VALUE_BITS(VB), .WEIGHT_FRAC_BITS(WF)) u_lerp_x (
        .clk(clk), .load(ctrl.load[XF+LS-1:XF]), .lo(c0), .hi(c1),
        .weight(wx_pipe_reg[XF-1]), .lo_fluid(m0), .hi_fluid(m1),
        .result(interpolated_value), .fluid()
    );

endmodule

[sv/mti_checker.sv]
// ----------------------------------------------------------------------------
// mti_checker
// Port-level checks on the request and result channels of the interpolator.
// ----------------------------------------------------------------------------
module mti_checker #(
    parameter int VALUE_BITS = mti_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [VALUE_BITS-1:0] interpolated_value
);

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped before acceptance");

    a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(interpolated_value))
        else $error("result payload changed while stalled");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("request refused while the result side is ready");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready ##1 out_ready
        ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
        |=> out_valid)
        else $error("result missing nine cycles after request");

endmodule

bind masked_trilinear_interpolation mti_checker #(.VALUE_BITS(VALUE_BITS)) u_mti_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .interpolated_value (interpolated_value)
);
